FILE: sv/debug_response_frame_parser_top_assert.svh
// Assertion macros used by the parser top-level RTL.
`ifndef DEBUG_RESPONSE_FRAME_PARSER_TOP_ASSERT_SVH
`define DEBUG_RESPONSE_FRAME_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DRFP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("drfp assertion failed");

// Next-cycle implication, checked outside reset.
`define DRFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("drfp assertion failed");

`endif

FILE: sv/drfp_pkg.sv
`default_nettype none
package drfp_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned WordWidth  = 32;
   localparam int unsigned CountWidth = 4;
   localparam int unsigned StatWidth  = 3;
   localparam int unsigned KindWidth  = 2;

   localparam logic [CountWidth-1:0] MAX_WORDS = 4'd8;

   localparam logic [ByteWidth-1:0] HDR_ACK = 8'h06;
   localparam logic [ByteWidth-1:0] HDR_NAK = 8'h15;
   localparam logic [ByteWidth-1:0] HDR_BEL = 8'h07;

   localparam logic [KindWidth-1:0] KIND_ACK = 2'd0;
   localparam logic [KindWidth-1:0] KIND_NAK = 2'd1;
   localparam logic [KindWidth-1:0] KIND_BEL = 2'd2;

   localparam logic [StatWidth-1:0] ST_ACK_OK  = 3'd0;
   localparam logic [StatWidth-1:0] ST_NAK     = 3'd1;
   localparam logic [StatWidth-1:0] ST_BEL     = 3'd2;
   localparam logic [StatWidth-1:0] ST_CHKERR  = 3'd3;
   localparam logic [StatWidth-1:0] ST_TIMEOUT = 3'd4;
   localparam logic [StatWidth-1:0] ST_UNEXP   = 3'd5;

   typedef struct packed {
      logic                 valid;
      logic [WordWidth-1:0] value_word;
      logic                 is_status;
      logic [StatWidth-1:0] status;
      logic                 is_last;
   } result_type;

endpackage
`default_nettype wire

FILE: sv/drfp_if.sv
`default_nettype none
interface drfp_req_if import drfp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [ByteWidth-1:0]  rx_byte;
   logic                  rx_timeout;
   logic [CountWidth-1:0] expected_count;

   modport source (output valid, rx_byte, rx_timeout, expected_count, input ready);
   modport sink (input valid, rx_byte, rx_timeout, expected_count, output ready);
endinterface

interface drfp_rsp_if import drfp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [WordWidth-1:0] value_word;
   logic                 is_status;
   logic [StatWidth-1:0] status;
   logic                 is_last;

   modport source (output valid, value_word, is_status, status, is_last, input ready);
   modport sink (input valid, value_word, is_status, status, is_last, output ready);
endinterface
`default_nettype wire

FILE: sv/drfp_core.sv
`default_nettype none
module drfp_core import drfp_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step_en,
   input  wire logic [ByteWidth-1:0]  rx_byte,
   input  wire logic                  rx_timeout,
   input  wire logic [CountWidth-1:0] expected_count,
   output      result_type            result
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_DATA,
      PH_TRAIL
   } phase_type;

   phase_type                   phase_ff, phase_in;
   logic [KindWidth-1:0]        kind_ff, kind_in;
   logic [CountWidth-1:0]       words_ff, words_in;
   logic [1:0]                  pos_ff, pos_in;
   logic [3*ByteWidth-1:0]      acc_ff, acc_in;
   logic [ByteWidth-1:0]        sum_ff, sum_in;
   logic [CountWidth-1:0]       sat_count;

   assign sat_count = (expected_count > MAX_WORDS) ? MAX_WORDS : expected_count;

   always_comb begin
      phase_in = phase_ff;
      kind_in  = kind_ff;
      words_in = words_ff;
      pos_in   = pos_ff;
      acc_in   = acc_ff;
      sum_in   = sum_ff;
      result   = '0;
      if (step_en) begin
         if (rx_timeout) begin
            // timeout wins over whatever the frame was doing
            phase_in         = PH_IDLE;
            words_in         = '0;
            pos_in           = '0;
            acc_in           = '0;
            result.valid     = 1'b1;
            result.is_status = 1'b1;
            result.status    = ST_TIMEOUT;
            result.is_last   = 1'b1;
         end else begin
            case (phase_ff)
               PH_DATA: begin
                  sum_in = sum_ff + rx_byte;
                  if (pos_ff != 2'd3) begin
                     acc_in = {acc_ff[2*ByteWidth-1:0], rx_byte};
                     pos_in = pos_ff + 2'd1;
                  end else begin
                     result.valid      = 1'b1;
                     result.value_word = {acc_ff, rx_byte};
                     pos_in            = '0;
                     acc_in            = '0;
                     words_in          = words_ff - 4'd1;
                     if (words_ff == 4'd1) begin
                        phase_in = PH_TRAIL;
                     end
                  end
               end
               PH_TRAIL: begin
                  phase_in         = PH_IDLE;
                  words_in         = '0;
                  pos_in           = '0;
                  acc_in           = '0;
                  result.valid     = 1'b1;
                  result.is_status = 1'b1;
                  result.status    = (rx_byte == sum_ff) ? {1'b0, kind_ff} : ST_CHKERR;
                  result.is_last   = 1'b1;
               end
               default: begin
                  // idle, and the unused phase code: this byte is a header
                  phase_in = PH_IDLE;
                  words_in = '0;
                  pos_in   = '0;
                  acc_in   = '0;
                  sum_in   = rx_byte;
                  if (rx_byte == HDR_ACK) begin
                     kind_in  = KIND_ACK;
                     words_in = sat_count;
                     phase_in = (sat_count != '0) ? PH_DATA : PH_TRAIL;
                  end else if (rx_byte == HDR_NAK) begin
                     kind_in  = KIND_NAK;
                     phase_in = PH_TRAIL;
                  end else if (rx_byte == HDR_BEL) begin
                     kind_in  = KIND_BEL;
                     phase_in = PH_TRAIL;
                  end else begin
                     result.valid     = 1'b1;
                     result.is_status = 1'b1;
                     result.status    = ST_UNEXP;
                     result.is_last   = 1'b1;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         kind_ff  <= KIND_ACK;
         words_ff <= '0;
         pos_ff   <= '0;
         acc_ff   <= '0;
         sum_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         words_ff <= words_in;
         pos_ff   <= pos_in;
         acc_ff   <= acc_in;
         sum_ff   <= sum_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/debug_response_frame_parser_top.sv
// Debug-link response frame parser.
// req_ch carries one received byte (or a receive timeout) per item, together
// with the word count sampled at an ACK header. rsp_ch carries at most one
// result per byte: a 32-bit big-endian data word, or an end-of-frame status
// (ack ok, nak, bel, checksum error, timeout, unexpected header) with is_last.
// Both channels use valid/ready; an item moves when both are high.
// A byte accepted into the input register has its result loaded into the result
// register when the byte advances, and the result is offered on rsp_ch from there.
// Throughput: one byte per cycle while rsp_ch does not stall, with the frame
// state updated as each byte moves between the two registers.
// Bytes that produce no result simply pass through without occupying rsp_ch.
// When rsp_ch stalls, the held result stays put, and one further byte waits
// in the input register; req_ch.ready drops only while both are full.
// Reset (synchronous, active high) empties both registers and returns the
// parser to idle, awaiting a header byte with a zero running sum.
`default_nettype none
`include "debug_response_frame_parser_top_assert.svh"
module debug_response_frame_parser_top import drfp_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   drfp_req_if.sink   req_ch,
   drfp_rsp_if.source rsp_ch
);

   logic                  in_valid_ff;
   logic [ByteWidth-1:0]  in_byte_ff;
   logic                  in_timeout_ff;
   logic [CountWidth-1:0] in_count_ff;

   logic                  out_valid_ff, out_valid_in;
   logic [WordWidth-1:0]  out_word_ff;
   logic                  out_is_status_ff;
   logic [StatWidth-1:0]  out_status_ff;
   logic                  out_is_last_ff;

   logic       advance;
   result_type result;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   drfp_core u_core (
      .clock          (clock),
      .reset          (reset),
      .step_en        (advance),
      .rx_byte        (in_byte_ff),
      .rx_timeout     (in_timeout_ff),
      .expected_count (in_count_ff),
      .result         (result)
   );

   always_comb begin
      if (advance) begin
         out_valid_in = result.valid;
      end else begin
         out_valid_in = out_valid_ff && !rsp_ch.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_byte_ff    <= req_ch.rx_byte;
         in_timeout_ff <= req_ch.rx_timeout;
         in_count_ff   <= req_ch.expected_count;
      end
      if (advance && result.valid) begin
         out_word_ff      <= result.value_word;
         out_is_status_ff <= result.is_status;
         out_status_ff    <= result.status;
         out_is_last_ff   <= result.is_last;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.value_word = out_word_ff;
   assign rsp_ch.is_status  = out_is_status_ff;
   assign rsp_ch.status     = out_status_ff;
   assign rsp_ch.is_last    = out_is_last_ff;

   `DRFP_ASSERT_NOW(a_status_is_last, clock, reset,
      out_valid_ff && out_is_status_ff, out_is_last_ff && (out_word_ff == '0))
   `DRFP_ASSERT_NOW(a_word_not_last, clock, reset,
      out_valid_ff && !out_is_status_ff, !out_is_last_ff && (out_status_ff == ST_ACK_OK))
   `DRFP_ASSERT_NEXT(a_timeout_reported, clock, reset,
      advance && in_timeout_ff,
      out_valid_ff && out_is_status_ff && (out_status_ff == ST_TIMEOUT))

endmodule
`default_nettype wire

FILE: sim/frame_result_check.sv
`default_nettype none
module frame_result_check import drfp_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   drfp_req_if       req,
   drfp_rsp_if       rsp,
   output int        mismatch_count,
   output int        results_owed
);

   typedef enum logic [1:0] {
      PHASE_IDLE    = 2'd0,
      PHASE_DATA    = 2'd1,
      PHASE_TRAILER = 2'd2
   } frame_phase_type;

   typedef struct packed {
      logic [WordWidth-1:0] value_word;
      logic                 is_status;
      logic [StatWidth-1:0] status;
      logic                 is_last;
   } frame_result_type;

   frame_phase_type       phase;
   logic [KindWidth-1:0]  hdr_kind;
   logic [CountWidth-1:0] words_left;
   logic [1:0]            byte_pos;
   logic [23:0]           word_acc;
   logic [ByteWidth-1:0]  frame_sum;
   frame_result_type      pending_results[$];
   int                    err_count = 0;

   function automatic void drop_to_idle();
      phase      = PHASE_IDLE;
      words_left = '0;
      byte_pos   = '0;
      word_acc   = '0;
   endfunction

   function automatic void push_status(input logic [StatWidth-1:0] st);
      frame_result_type r;
      r.value_word = '0;
      r.is_status  = 1'b1;
      r.status     = st;
      r.is_last    = 1'b1;
      pending_results.push_back(r);
   endfunction

   // advance the frame state by one received item, queue what it yields
   function automatic void parse_rx_byte(input logic [ByteWidth-1:0] b, input logic timed_out,
                                         input logic [CountWidth-1:0] cnt);
      frame_result_type r;
      logic [StatWidth-1:0] st;
      if (timed_out) begin
         drop_to_idle();
         push_status(ST_TIMEOUT);
         return;
      end
      case (phase)
         PHASE_DATA: begin
            frame_sum = frame_sum + b;
            if (byte_pos != 2'd3) begin
               word_acc = {word_acc[15:0], b};
               byte_pos = byte_pos + 2'd1;
            end else begin
               r.value_word = {word_acc, b};
               r.is_status  = 1'b0;
               r.status     = ST_ACK_OK;
               r.is_last    = 1'b0;
               pending_results.push_back(r);
               byte_pos   = '0;
               word_acc   = '0;
               words_left = words_left - 1'b1;
               if (words_left == '0) phase = PHASE_TRAILER;
            end
         end
         PHASE_TRAILER: begin
            if (b != frame_sum) st = ST_CHKERR;
            else if (hdr_kind == KIND_NAK) st = ST_NAK;
            else if (hdr_kind == KIND_BEL) st = ST_BEL;
            else st = ST_ACK_OK;
            drop_to_idle();
            push_status(st);
         end
         default: begin
            drop_to_idle();
            frame_sum = b;
            if (b == HDR_ACK) begin
               hdr_kind   = KIND_ACK;
               words_left = (cnt > MAX_WORDS) ? MAX_WORDS : cnt;
               phase      = (words_left != '0) ? PHASE_DATA : PHASE_TRAILER;
            end else if (b == HDR_NAK) begin
               hdr_kind = KIND_NAK;
               phase    = PHASE_TRAILER;
            end else if (b == HDR_BEL) begin
               hdr_kind = KIND_BEL;
               phase    = PHASE_TRAILER;
            end else begin
               push_status(ST_UNEXP);
            end
         end
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [WordWidth-1:0] exp_v,
                                       input logic [WordWidth-1:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
         err_count++;
      end
   endfunction

   always @(posedge clock) begin
      frame_result_type want;
      if (reset) begin
         drop_to_idle();
         hdr_kind  = KIND_ACK;
         frame_sum = '0;
         pending_results.delete();
      end else begin
         if (req.valid && req.ready)
            parse_rx_byte(req.rx_byte, req.rx_timeout, req.expected_count);
         if (rsp.valid && rsp.ready) begin
            if (pending_results.size() == 0) begin
               $error("result with no item awaiting it: value_word 0x%0h status %0d",
                      rsp.value_word, rsp.status);
               err_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("value_word", want.value_word, rsp.value_word);
               check_field("is_status", WordWidth'(want.is_status),
                           WordWidth'(rsp.is_status));
               check_field("status", WordWidth'(want.status), WordWidth'(rsp.status));
               check_field("is_last", WordWidth'(want.is_last), WordWidth'(rsp.is_last));
            end
         end
      end
      results_owed   <= pending_results.size();
      mismatch_count <= err_count;
   end

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
`default_nettype none
module tb_top;
   import drfp_pkg::*;

   localparam int RandomItems = 1450;
   localparam int CycleLimit  = 500000;

   typedef enum logic [1:0] {
      RX_OPEN     = 2'd0,
      RX_SPOTTY   = 2'd1,
      RX_EVERY3RD = 2'd2,
      RX_BLOCKS   = 2'd3
   } rx_stall_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic sink_ready = 1'b0;
   int   cycle_count = 0;
   int   items_sent = 0;
   int   burst_left = 0;
   int   mismatch_count;
   int   results_owed;

   rx_stall_type stall_mode = RX_OPEN;
   int           mode_left = 0;
   int           hold_left = 0;

   drfp_req_if req_ch ();
   drfp_rsp_if rsp_ch ();

   assign rsp_ch.ready = sink_ready;

   debug_response_frame_parser_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   frame_result_check u_check (
      .clock          (clock),
      .reset          (reset),
      .req            (req_ch),
      .rsp            (rsp_ch),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   always #5 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // result-side backpressure: a randomly chosen stall pattern, changed when its mode counter runs out
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= rx_stall_type'($urandom_range(0, 3));
         mode_left  <= $urandom_range(20, 200);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         RX_OPEN:     sink_ready <= 1'b1;
         RX_SPOTTY:   sink_ready <= ($urandom_range(0, 3) != 0);
         RX_EVERY3RD: sink_ready <= (mode_left % 3 == 0);
         default: begin
            if (hold_left != 0) begin
               sink_ready <= 1'b0;
               hold_left  <= hold_left - 1;
            end else begin
               sink_ready <= 1'b1;
               hold_left  <= ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : 0;
            end
         end
      endcase
   end

   function automatic logic [7:0] rand_payload_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_item(input logic [7:0] b, input logic timed_out, input logic [3:0] cnt);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                  : $urandom_range(1, 12);
      end
      req_ch.valid          <= 1'b1;
      req_ch.rx_byte        <= b;
      req_ch.rx_timeout     <= timed_out;
      req_ch.expected_count <= cnt;
      do @(posedge clock); while (!req_ch.ready);
      burst_left--;
      items_sent++;
   endtask

   // cut_at: position within the frame replaced by a timeout, -1 for none
   // fill: value for every payload byte, -1 for random payload
   task automatic send_frame(input logic [7:0] hdr, input logic [3:0] cnt,
                             input bit good_trailer, input int cut_at, input int fill);
      int          n_words;
      logic [7:0]  sum;
      logic [7:0]  b;
      if (cut_at == 0) begin
         send_item(8'($urandom), 1'b1, 4'($urandom));
         return;
      end
      send_item(hdr, 1'b0, cnt);
      if (hdr != HDR_ACK && hdr != HDR_NAK && hdr != HDR_BEL) return;
      n_words = (hdr == HDR_ACK) ? ((cnt > MAX_WORDS) ? MAX_WORDS : cnt) : 0;
      sum = hdr;
      for (int i = 0; i <= 4 * n_words; i++) begin
         if (i + 1 == cut_at) begin
            send_item(8'($urandom), 1'b1, 4'($urandom));
            return;
         end
         if (i < 4 * n_words) begin
            b = (fill < 0) ? rand_payload_byte() : 8'(fill);
            sum = sum + b;
         end else begin
            b = good_trailer ? sum : 8'(sum + $urandom_range(1, 255));
         end
         send_item(b, 1'b0, 4'($urandom));
      end
   endtask

   initial begin
      logic [7:0] hdr;
      logic [3:0] cnt;
      int         pick;
      req_ch.valid          = 1'b0;
      req_ch.rx_byte        = '0;
      req_ch.rx_timeout     = 1'b0;
      req_ch.expected_count = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners
      send_item(8'hff, 1'b1, 4'hf);                 // timeout while idle
      send_frame(HDR_ACK, 4'd0, 1'b1, -1, -1);      // empty ACK, trailer right after
      send_frame(HDR_ACK, 4'd0, 1'b0, -1, -1);      // bad trailer
      send_frame(HDR_NAK, 4'd0, 1'b1, -1, -1);
      send_frame(HDR_BEL, 4'd5, 1'b0, -1, -1);
      send_frame(8'h00, 4'd0, 1'b1, -1, -1);        // unexpected headers
      send_frame(8'hff, 4'hf, 1'b1, -1, -1);
      send_frame(HDR_ACK, 4'd1, 1'b1, -1, 8'hff);   // all-ones word
      send_frame(HDR_ACK, 4'd2, 1'b1, 3, -1);       // timeout mid-word
      send_frame(HDR_NAK, 4'd0, 1'b1, 1, -1);       // timeout in place of trailer

      while (items_sent < RandomItems) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_item(8'($urandom), 1'b1, 4'($urandom));
         end else if (pick < 16) begin
            send_frame(8'($urandom), 4'($urandom), 1'b1, -1, -1);
         end else begin
            pick = $urandom_range(0, 99);
            hdr  = (pick < 60) ? HDR_ACK : (pick < 80) ? HDR_NAK : HDR_BEL;
            cnt  = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 8))
                                               : 4'($urandom_range(9, 15));
            send_frame(hdr, cnt, $urandom_range(0, 99) < 85,
                       ($urandom_range(0, 9) == 0) ? $urandom_range(0, 33) : -1, -1);
         end
      end
      req_ch.valid <= 1'b0;

      // let the count of owed results catch up with the last item
      @(posedge clock);
      wait (results_owed == 0);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && results_owed == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      wait (cycle_count >= CycleLimit);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
`default_nettype wire

FILE: files.f
+incdir+sv
sv/drfp_pkg.sv
sv/drfp_if.sv
sv/drfp_core.sv
sv/debug_response_frame_parser_top.sv
sim/frame_result_check.sv
sim/tb_top.sv
